// ===== src/rwh_pkg.sv =====
// ----------------------------------------------------------------------------
// rwh_pkg
// Shared types and constants for the RIFF/WAVE header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rwh_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [31:0] MIN_FILE_BYTES = 32'd44;
  localparam logic [31:0] FMT_MIN_BYTES  = 32'd16;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_SHORT    = 3'd1,
    ST_NO_RIFF  = 3'd2,
    ST_NO_WAVE  = 3'd3,
    ST_NO_DATA  = 3'd4
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] format_tag;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] sample_bits;
    logic [31:0] data_offset;
    logic [31:0] data_length;
  } result_t;

endpackage : rwh_pkg

`default_nettype wire

// ===== src/rwh_core.sv =====
// ----------------------------------------------------------------------------
// rwh_core
// Per-byte parse state: header check, chunk walk, fmt capture, result build.
// ----------------------------------------------------------------------------
`default_nettype none

module rwh_core import rwh_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        take,
  input  wire logic [7:0]  file_byte,
  input  wire logic        end_of_file,
  output result_t          result
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_CHUNK  = 2'd1,
    PH_FMT    = 2'd2,
    PH_SKIP   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    FAULT_NONE = 2'd0,
    FAULT_RIFF = 2'd1,
    FAULT_WAVE = 2'd2
  } fault_t;

  phase_t      phase_r,      phase_nxt;
  fault_t      fault_r,      fault_nxt;
  logic [31:0] count_r,      count_nxt;
  logic [31:0] tag_r,        tag_nxt;
  logic [31:0] len_r,        len_nxt;
  logic [32:0] skip_r,       skip_nxt;
  logic [3:0]  index_r,      index_nxt;
  logic [15:0] fmt_r,        fmt_nxt;
  logic [15:0] chans_r,      chans_nxt;
  logic [31:0] rate_r,       rate_nxt;
  logic [31:0] brate_r,      brate_nxt;
  logic [15:0] align_r,      align_nxt;
  logic [15:0] bits_r,       bits_nxt;
  logic [31:0] dstart_r,     dstart_nxt;
  logic [31:0] dlen_r,       dlen_nxt;

  logic [32:0] padded;
  logic [32:0] skip_dec;

  always_comb begin
    phase_nxt  = phase_r;
    fault_nxt  = fault_r;
    tag_nxt    = tag_r;
    len_nxt    = len_r;
    skip_nxt   = skip_r;
    index_nxt  = index_r;
    fmt_nxt    = fmt_r;
    chans_nxt  = chans_r;
    rate_nxt   = rate_r;
    brate_nxt  = brate_r;
    align_nxt  = align_r;
    bits_nxt   = bits_r;
    dstart_nxt = dstart_r;
    dlen_nxt   = dlen_r;
    count_nxt  = (count_r == '1) ? count_r : count_r + 32'd1;
    padded     = '0;
    skip_dec   = (skip_r != '0) ? skip_r - 33'd1 : skip_r;

    unique case (phase_r)
      PH_HEADER: begin
        tag_nxt = {tag_r[23:0], file_byte};
        if (count_r == 32'd3 && tag_nxt != TAG_RIFF && fault_r == FAULT_NONE) begin
          fault_nxt = FAULT_RIFF;
        end
        if (count_r == 32'd11) begin
          if (tag_nxt != TAG_WAVE && fault_r == FAULT_NONE) begin
            fault_nxt = FAULT_WAVE;
          end
          phase_nxt = PH_CHUNK;
          index_nxt = '0;
        end
      end
      PH_CHUNK: begin
        if (index_r < 4'd4) begin
          tag_nxt = {tag_r[23:0], file_byte};
        end else begin
          len_nxt = {file_byte, len_r[31:8]};
        end
        if (index_r >= 4'd7) begin
          // chunk header complete: pick fmt capture, data capture or skip
          padded    = {1'b0, len_nxt} + {32'd0, len_nxt[0]};
          index_nxt = '0;
          if (tag_r == TAG_FMT && len_nxt >= FMT_MIN_BYTES) begin
            fmt_nxt   = '0;
            chans_nxt = '0;
            rate_nxt  = '0;
            brate_nxt = '0;
            align_nxt = '0;
            bits_nxt  = '0;
            skip_nxt  = padded - {1'b0, FMT_MIN_BYTES};
            phase_nxt = PH_FMT;
          end else begin
            if (tag_r == TAG_DATA) begin
              dstart_nxt = count_nxt;
              dlen_nxt   = len_nxt;
            end
            skip_nxt  = padded;
            phase_nxt = (padded == '0) ? PH_CHUNK : PH_SKIP;
          end
        end else begin
          index_nxt = index_r + 4'd1;
        end
      end
      PH_FMT: begin
        if (index_r < 4'd2) begin
          fmt_nxt[{index_r[0], 3'b000} +: 8] = file_byte;
        end else if (index_r < 4'd4) begin
          chans_nxt[{index_r[0], 3'b000} +: 8] = file_byte;
        end else if (index_r < 4'd8) begin
          rate_nxt[{index_r[1:0], 3'b000} +: 8] = file_byte;
        end else if (index_r < 4'd12) begin
          brate_nxt[{index_r[1:0], 3'b000} +: 8] = file_byte;
        end else if (index_r < 4'd14) begin
          align_nxt[{index_r[0], 3'b000} +: 8] = file_byte;
        end else begin
          bits_nxt[{index_r[0], 3'b000} +: 8] = file_byte;
        end
        if (index_r == 4'd15) begin
          index_nxt = '0;
          phase_nxt = (skip_r == '0) ? PH_CHUNK : PH_SKIP;
        end else begin
          index_nxt = index_r + 4'd1;
        end
      end
      PH_SKIP: begin
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          phase_nxt = PH_CHUNK;
          index_nxt = '0;
        end
      end
      default: phase_nxt = PH_HEADER;
    endcase
  end

  // result as seen after the final byte; fields zero unless status is ok
  always_comb begin
    result = '0;
    if (count_nxt < MIN_FILE_BYTES) begin
      result.status = ST_SHORT;
    end else if (fault_nxt == FAULT_RIFF) begin
      result.status = ST_NO_RIFF;
    end else if (fault_nxt == FAULT_WAVE) begin
      result.status = ST_NO_WAVE;
    end else if (dlen_nxt == '0) begin
      result.status = ST_NO_DATA;
    end else begin
      result.status        = ST_OK;
      result.format_tag    = fmt_nxt;
      result.channel_count = chans_nxt;
      result.sample_rate   = rate_nxt;
      result.byte_rate     = brate_nxt;
      result.block_align   = align_nxt;
      result.sample_bits   = bits_nxt;
      result.data_offset   = dstart_nxt;
      result.data_length   = dlen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && end_of_file)) begin
      phase_r  <= PH_HEADER;
      fault_r  <= FAULT_NONE;
      count_r  <= '0;
      tag_r    <= '0;
      len_r    <= '0;
      skip_r   <= '0;
      index_r  <= '0;
      fmt_r    <= '0;
      chans_r  <= '0;
      rate_r   <= '0;
      brate_r  <= '0;
      align_r  <= '0;
      bits_r   <= '0;
      dstart_r <= '0;
      dlen_r   <= '0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      fault_r  <= fault_nxt;
      count_r  <= count_nxt;
      tag_r    <= tag_nxt;
      len_r    <= len_nxt;
      skip_r   <= skip_nxt;
      index_r  <= index_nxt;
      fmt_r    <= fmt_nxt;
      chans_r  <= chans_nxt;
      rate_r   <= rate_nxt;
      brate_r  <= brate_nxt;
      align_r  <= align_nxt;
      bits_r   <= bits_nxt;
      dstart_r <= dstart_nxt;
      dlen_r   <= dlen_nxt;
    end
  end

endmodule : rwh_core

`default_nettype wire

// ===== src/riff_wave_header_parser.sv =====
// ----------------------------------------------------------------------------
// riff_wave_header_parser
// Streaming RIFF/WAVE header parser, one file byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one file byte per item, in file order,
//   with in_end_of_file high on the final byte of the file.
//   Result channel (out_valid/out_ready): one result item per file, made on
//   the final byte: status plus fmt fields, data offset and data length.
//   Fields other than status read zero whenever status is not ok.
// Timing:
//   Each byte is folded into the parse state in the cycle it is accepted, so
//   the block takes one byte per cycle while in_ready is high. The result item
//   appears on out_valid in the cycle after the final byte is accepted. The
//   rate is set by the single parse-state update per byte.
// Reset and stalls:
//   rst_n (synchronous, active low) clears the parse state and drops any
//   pending result. After each final byte the parse state returns to its
//   reset values, so the next file may follow in the next cycle.
//   While a result waits on a stalled receiver, in_ready stays low; bytes
//   keep flowing whenever the result register is empty or being drained.
// ----------------------------------------------------------------------------
`default_nettype none

module riff_wave_header_parser import rwh_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_file_byte,
  input  wire logic        in_end_of_file,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [15:0]      out_format_tag,
  output logic [15:0]      out_channel_count,
  output logic [31:0]      out_sample_rate,
  output logic [31:0]      out_byte_rate,
  output logic [15:0]      out_block_align,
  output logic [15:0]      out_sample_bits,
  output logic [31:0]      out_data_offset,
  output logic [31:0]      out_data_length
);

  logic    in_accept;
  result_t core_result;
  result_t out_r;
  logic    out_valid_r;

  // accept a byte whenever the result register is free or draining this cycle
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  rwh_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (in_accept),
    .file_byte   (in_file_byte),
    .end_of_file (in_end_of_file),
    .result      (core_result)
  );

  // result register: load on the final byte, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && in_end_of_file) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_end_of_file) begin
      out_r <= core_result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_format_tag    = out_r.format_tag;
  assign out_channel_count = out_r.channel_count;
  assign out_sample_rate   = out_r.sample_rate;
  assign out_byte_rate     = out_r.byte_rate;
  assign out_block_align   = out_r.block_align;
  assign out_sample_bits   = out_r.sample_bits;
  assign out_data_offset   = out_r.data_offset;
  assign out_data_length   = out_r.data_length;

  // the final byte always produces a result in the next cycle
  a_eof_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_end_of_file |=> out_valid)
    else $error("final byte did not produce a result");

  // a drained result is not replaced unless a final byte came in
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_end_of_file && out_ready |=> !out_valid)
    else $error("result appeared without a final byte");

  // an empty result register never blocks input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // error results carry zero data length, data offset and sample rate
  a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_data_length == '0 && out_data_offset == '0 && out_sample_rate == '0)
    else $error("error result with nonzero fields");

endmodule : riff_wave_header_parser

`default_nettype wire
